// File: rtl/shr_pkg.sv
// ============================================================================
// shr_pkg
// Shared types, constants and the half-step coil table for the stepper
// half-step ramp generator.
// ============================================================================
`default_nettype none

package shr_pkg;

    localparam int DELAY_W = 3;
    localparam int SPL_W   = 10;
    localparam int PHASE_W = 3;
    localparam int COUNT_W = 13;
    localparam int COIL_W  = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_START = 1'b1
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SLOW_DELAY      = 2'd0,
        REG_FAST_DELAY      = 2'd1,
        REG_STEPS_PER_LEVEL = 2'd2,
        REG_UNUSED          = 2'd3
    } t_reg_idx;

    localparam logic [DELAY_W-1:0] SLOW_DELAY_RST      = 3'd6;
    localparam logic [DELAY_W-1:0] FAST_DELAY_RST      = 3'd1;
    localparam logic [SPL_W-1:0]   STEPS_PER_LEVEL_RST = 10'd250;
    localparam logic [DELAY_W-1:0] MAX_LEVEL           = 3'd7;

    typedef struct packed {
        logic [DELAY_W-1:0] slow_delay;
        logic [DELAY_W-1:0] fast_delay;
        logic [SPL_W-1:0]   steps_per_level;
    } t_cfg;

    typedef struct packed {
        logic [COIL_W-1:0] coils;
        logic              busy_res;
        logic              stepped;
        logic              finished;
    } t_result;

    typedef struct packed {
        logic               running;
        logic [DELAY_W-1:0] tick_count;
        logic [COUNT_W-1:0] level_step_count;
    } t_status;

    // Half-step pattern: one coil, two coils, one coil, ... around the rotor.
    function automatic logic [COIL_W-1:0] coil_pattern(input logic [PHASE_W-1:0] phase);
        logic [COIL_W-1:0] pat;
        case (phase)
            3'd0:    pat = 4'b0001;
            3'd1:    pat = 4'b0011;
            3'd2:    pat = 4'b0010;
            3'd3:    pat = 4'b0110;
            3'd4:    pat = 4'b0100;
            3'd5:    pat = 4'b1100;
            3'd6:    pat = 4'b1000;
            default: pat = 4'b1001;
        endcase
        return pat;
    endfunction

endpackage

`default_nettype wire

// File: rtl/shr_ifs.sv
// ============================================================================
// shr_ifs
// Valid/ready channel interfaces for command items, result items and
// configuration writes.
// ============================================================================
`default_nettype none

interface shr_in_if;
    logic valid;
    logic ready;
    logic opcode;
    logic ramp_up;
    logic forward;

    modport source (output valid, output opcode, output ramp_up, output forward,
                    input ready);
    modport sink   (input valid, input opcode, input ramp_up, input forward,
                    output ready);
endinterface

interface shr_out_if;
    logic                         valid;
    logic                         ready;
    logic [shr_pkg::COIL_W-1:0]   coils;
    logic                         busy_res;
    logic                         stepped;
    logic                         finished;

    modport source (output valid, output coils, output busy_res, output stepped,
                    output finished, input ready);
    modport sink   (input valid, input coils, input busy_res, input stepped,
                    input finished, output ready);
endinterface

interface shr_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [shr_pkg::CFG_IDX_W-1:0]   index;
    logic [shr_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/stepper_half_step_ramp.sv
// ============================================================================
// stepper_half_step_ramp
// Half-step stepper coil driver with an accelerate/decelerate speed ramp.
// ============================================================================
// Each input item is either a millisecond tick or a start command, and every
// item returns exactly one result carrying the four-coil pattern, a busy flag,
// and flags telling whether this item moved the phase or ended the move. The
// block takes one item per clock cycle while not stalled: an item is captured
// in an input register, the move state is updated by combinational counter
// and compare logic, and the result lands in an output register that is
// loaded when the staged item advances. The input register takes a new item
// whenever it is empty or its item moves on in the same cycle; the staged
// item moves on when the result register is empty or is being emptied in
// that cycle. With both registers full and the receiver holding off, the
// input stalls. Configuration writes are taken at any time and should only
// be issued while no item is in flight.
// ============================================================================
`default_nettype none

module stepper_half_step_ramp (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    shr_in_if.sink    i_in,
    shr_cfg_if.sink   i_cfg,
    shr_out_if.source o_out
);

    // Input stage register.
    logic              r_in_valid;
    shr_pkg::t_opcode  r_in_opcode;
    logic              r_in_ramp_up;
    logic              r_in_forward;

    // Result register.
    logic              r_out_valid;
    shr_pkg::t_result  r_out_res;

    logic              advance;
    shr_pkg::t_cfg     cfg;
    shr_pkg::t_result  core_res;
    shr_pkg::t_status  core_status;

    // The staged item moves on when the result register is empty or is being
    // drained this cycle; the input stage then frees up for a new item.
    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_opcode  <= shr_pkg::t_opcode'(i_in.opcode);
            r_in_ramp_up <= i_in.ramp_up;
            r_in_forward <= i_in.forward;
        end
    end

    shr_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // The core commits its state only when the staged item advances, so the
    // state seen by each item is exactly what the previous item left behind.
    shr_ramp_core u_ramp_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (advance),
        .i_opcode  (r_in_opcode),
        .i_ramp_up (r_in_ramp_up),
        .i_forward (r_in_forward),
        .i_cfg     (cfg),
        .o_result  (core_res),
        .o_status  (core_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_res <= core_res;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.coils    = r_out_res.coils;
    assign o_out.busy_res = r_out_res.busy_res;
    assign o_out.stepped  = r_out_res.stepped;
    assign o_out.finished = r_out_res.finished;

`ifndef SYNTHESIS
    // A result never both steps and finishes, and a finishing result is idle.
    a_step_finish_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_res.stepped && r_out_res.finished)
                        && !(r_out_res.finished && r_out_res.busy_res))
        else $error("result both stepped and finished, or finished while busy");

    // While idle the tick and step counters stay cleared.
    a_idle_counters_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !core_status.running |-> (core_status.tick_count == '0)
                                 && (core_status.level_step_count == '0))
        else $error("counters not cleared while idle");

    // A staged item that cannot advance stays staged.
    a_stage_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> r_in_valid)
        else $error("staged item dropped");

    // A busy move always has a nonzero step count at its level.
    a_running_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_status.running |-> (core_status.level_step_count != '0))
        else $error("running with zero level step count");
`endif

endmodule

`default_nettype wire

// File: rtl/shr_cfg_regs.sv
// ============================================================================
// shr_cfg_regs
// Configuration register file: slow delay, fast delay and steps per level.
// ============================================================================
`default_nettype none

module shr_cfg_regs (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    shr_cfg_if.sink            i_cfg,
    output shr_pkg::t_cfg      o_cfg
);

    shr_pkg::t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slow_delay      <= shr_pkg::SLOW_DELAY_RST;
            r_cfg.fast_delay      <= shr_pkg::FAST_DELAY_RST;
            r_cfg.steps_per_level <= shr_pkg::STEPS_PER_LEVEL_RST;
        end else if (i_cfg.valid) begin
            unique case (shr_pkg::t_reg_idx'(i_cfg.index))
                shr_pkg::REG_SLOW_DELAY: begin
                    r_cfg.slow_delay <= i_cfg.data[shr_pkg::DELAY_W-1:0];
                end
                shr_pkg::REG_FAST_DELAY: begin
                    r_cfg.fast_delay <= i_cfg.data[shr_pkg::DELAY_W-1:0];
                end
                shr_pkg::REG_STEPS_PER_LEVEL: begin
                    r_cfg.steps_per_level <= i_cfg.data[shr_pkg::SPL_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: rtl/shr_ramp_core.sv
// ============================================================================
// shr_ramp_core
// Move state and the next-state update for a tick or start item: tick
// counting, per-level step counting, level changes and the phase index.
// ============================================================================
`default_nettype none

module shr_ramp_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire shr_pkg::t_opcode  i_opcode,
    input  wire logic              i_ramp_up,
    input  wire logic              i_forward,
    input  wire shr_pkg::t_cfg     i_cfg,
    output shr_pkg::t_result       o_result,
    output shr_pkg::t_status       o_status
);

    logic [shr_pkg::PHASE_W-1:0] r_phase,     n_phase;
    logic                        r_running,   n_running;
    logic                        r_accel,     n_accel;
    logic                        r_fwd,       n_fwd;
    logic [shr_pkg::DELAY_W-1:0] r_level,     n_level;
    logic [shr_pkg::COUNT_W-1:0] r_steps,     n_steps;
    logic [shr_pkg::DELAY_W-1:0] r_ticks,     n_ticks;

    logic                        stepped;
    logic                        finished;
    logic [shr_pkg::DELAY_W:0]   waited;
    logic                        delay_done;
    logic [shr_pkg::DELAY_W-1:0] inv_level;
    logic [shr_pkg::COUNT_W-1:0] target;
    logic                        level_done;
    logic [shr_pkg::DELAY_W-1:0] next_level;
    logic [shr_pkg::PHASE_W-1:0] step_phase;

    always_comb begin
        n_phase   = r_phase;
        n_running = r_running;
        n_accel   = r_accel;
        n_fwd     = r_fwd;
        n_level   = r_level;
        n_steps   = r_steps;
        n_ticks   = r_ticks;
        stepped   = 1'b0;
        finished  = 1'b0;

        waited     = {1'b0, r_ticks} + 4'd1;
        delay_done = (r_level == '0) || (waited >= {1'b0, r_level});
        inv_level  = shr_pkg::MAX_LEVEL - r_level;
        // Steps to run at this level: (7 - level) * steps_per_level + 1.
        target     = shr_pkg::COUNT_W'({10'd0, inv_level} * {3'd0, i_cfg.steps_per_level})
                     + 13'd1;

        if (r_accel) begin
            level_done = (r_level == '0) || ((r_level - 3'd1) <= i_cfg.fast_delay);
            next_level = r_level - 3'd1;
        end else begin
            level_done = (({1'b0, r_level} + 4'd1) >= {1'b0, i_cfg.slow_delay})
                         || (r_level == shr_pkg::MAX_LEVEL);
            next_level = r_level + 3'd1;
        end

        if (i_opcode == shr_pkg::OP_START) begin
            step_phase = i_forward ? r_phase + 3'd1 : r_phase - 3'd1;
        end else begin
            step_phase = r_fwd ? r_phase + 3'd1 : r_phase - 3'd1;
        end

        if (i_opcode == shr_pkg::OP_START) begin
            if (!r_running) begin
                n_running = 1'b1;
                n_accel   = i_ramp_up;
                n_fwd     = i_forward;
                n_level   = i_ramp_up ? i_cfg.slow_delay : i_cfg.fast_delay;
                n_phase   = step_phase;
                n_ticks   = '0;
                n_steps   = 13'd1;
                stepped   = 1'b1;
            end
        end else if (r_running) begin
            if (!delay_done) begin
                n_ticks = waited[shr_pkg::DELAY_W-1:0];
            end else if (r_steps < target) begin
                n_phase = step_phase;
                n_ticks = '0;
                n_steps = r_steps + 13'd1;
                stepped = 1'b1;
            end else if (level_done) begin
                n_running = 1'b0;
                n_ticks   = '0;
                n_steps   = '0;
                finished  = 1'b1;
            end else begin
                n_level = next_level;
                n_phase = step_phase;
                n_ticks = '0;
                n_steps = 13'd1;
                stepped = 1'b1;
            end
        end

        o_result.coils    = shr_pkg::coil_pattern(n_phase);
        o_result.busy_res = n_running;
        o_result.stepped  = stepped;
        o_result.finished = finished;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= '0;
            r_running <= 1'b0;
            r_accel   <= 1'b0;
            r_fwd     <= 1'b0;
            r_level   <= '0;
            r_steps   <= '0;
            r_ticks   <= '0;
        end else if (i_en) begin
            r_phase   <= n_phase;
            r_running <= n_running;
            r_accel   <= n_accel;
            r_fwd     <= n_fwd;
            r_level   <= n_level;
            r_steps   <= n_steps;
            r_ticks   <= n_ticks;
        end
    end

    assign o_status.running          = r_running;
    assign o_status.tick_count       = r_ticks;
    assign o_status.level_step_count = r_steps;

endmodule

`default_nettype wire
